FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the escape-time unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define MBE_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define MBE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mbe_pkg.sv
// Shared types and constants of the escape-time unit.
// No dependencies; used by mbe_cell and the top level.
package mbe_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd1000;

    // control part of one ring slot
    typedef struct packed {
        logic             valid;   // slot holds a point
        logic             done;    // point finished, count is final
        logic             pend;    // z holds an update whose magnitude is not yet checked
        logic [CNT_W-1:0] count;   // confirmed updates so far
    } t_slot_ctl;

endpackage

FILE: hw/rtl/mbe_cell.sv
// One iteration cell of the escape-time ring: squares/product stage, then
// update and escape-test stage. Depends on mbe_pkg.
module mbe_cell #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int TAG_W       = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mbe_pkg::CNT_W-1:0]         i_max_iter,
    input  mbe_pkg::t_slot_ctl                i_ctl,
    input  logic [TAG_W-1:0]                  i_tag,
    input  logic signed [FRAC_BITS+2:0]       i_x,
    input  logic signed [FRAC_BITS+2:0]       i_y,
    input  logic signed [COORD_WIDTH-1:0]     i_cr,
    input  logic signed [COORD_WIDTH-1:0]     i_ci,
    output mbe_pkg::t_slot_ctl                o_ctl,
    output logic [TAG_W-1:0]                  o_tag,
    output logic signed [FRAC_BITS+2:0]       o_x,
    output logic signed [FRAC_BITS+2:0]       o_y,
    output logic signed [COORD_WIDTH-1:0]     o_cr,
    output logic signed [COORD_WIDTH-1:0]     o_ci
);
    import mbe_pkg::*;

    localparam int ZW   = FRAC_BITS + 3;          // z component width
    localparam int PW   = 2 * ZW;                 // product width
    localparam int QW   = PW - FRAC_BITS + 1;     // product after rescale
    localparam int SW   = ((QW > COORD_WIDTH) ? QW : COORD_WIDTH) + 1;
    localparam logic signed [SW-1:0] BOUND  = SW'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [SW-1:0] NBOUND = -BOUND;
    localparam logic signed [PW:0]   MAG_LIMIT = (PW+1)'(1) <<< (2 * FRAC_BITS + 2);

    // stage A: products
    t_slot_ctl                     r_a_ctl;
    logic [TAG_W-1:0]              r_a_tag;
    logic signed [ZW-1:0]          r_a_x, r_a_y;
    logic signed [COORD_WIDTH-1:0] r_a_cr, r_a_ci;
    logic signed [PW-1:0]          r_xx, r_yy, r_xy;
    logic signed [PW-1:0]          n_xx, n_yy, n_xy;

    // stage B: updated slot
    t_slot_ctl                     r_b_ctl, n_ctl;
    logic [TAG_W-1:0]              r_b_tag;
    logic signed [ZW-1:0]          r_b_x, r_b_y, n_x, n_y;
    logic signed [COORD_WIDTH-1:0] r_b_cr, r_b_ci;

    logic signed [PW:0]            w_mag;
    logic signed [PW-1:0]          w_diff;
    logic signed [QW-2:0]          w_re_q;
    logic signed [QW-1:0]          w_im_q;
    logic signed [SW-1:0]          w_re, w_im;
    logic                          w_oob;
    logic [CNT_W-1:0]              w_cnt;

    assign n_xx = i_x * i_x;
    assign n_yy = i_y * i_y;
    assign n_xy = i_x * i_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tag <= i_tag;
        r_a_x   <= i_x;
        r_a_y   <= i_y;
        r_a_cr  <= i_cr;
        r_a_ci  <= i_ci;
        r_xx    <= n_xx;
        r_yy    <= n_yy;
        r_xy    <= n_xy;
        r_b_tag <= r_a_tag;
        r_b_x   <= n_x;
        r_b_y   <= n_y;
        r_b_cr  <= r_a_cr;
        r_b_ci  <= r_a_ci;
    end

    // escape test of the z that came in, and the next update from it
    assign w_mag  = (PW+1)'(r_xx) + (PW+1)'(r_yy);
    assign w_diff = r_xx - r_yy;
    assign w_re_q = w_diff[PW-1:FRAC_BITS];
    assign w_im_q = r_xy[PW-1:FRAC_BITS-1];     // 2xy rescaled, low bits truncated
    assign w_re   = SW'(w_re_q) + SW'(r_a_cr);
    assign w_im   = SW'(w_im_q) + SW'(r_a_ci);
    assign w_oob  = (w_re > BOUND) || (w_re < NBOUND) ||
                    (w_im > BOUND) || (w_im < NBOUND);
    assign w_cnt  = r_a_ctl.pend ? (r_a_ctl.count + 16'd1) : r_a_ctl.count;

    always_comb begin
        n_ctl = r_a_ctl;
        n_x   = r_a_x;
        n_y   = r_a_y;
        if (r_a_ctl.valid && !r_a_ctl.done) begin
            priority if (r_a_ctl.pend && (w_mag > MAG_LIMIT)) begin
                n_ctl.done = 1'b1;
            end else if (w_cnt == i_max_iter) begin
                n_ctl.done  = 1'b1;
                n_ctl.count = w_cnt;
            end else if (w_oob) begin
                n_ctl.done  = 1'b1;
                n_ctl.count = w_cnt;
            end else begin
                n_ctl.pend  = 1'b1;
                n_ctl.count = w_cnt;
                n_x         = w_re[ZW-1:0];
                n_y         = w_im[ZW-1:0];
            end
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_tag = r_b_tag;
    assign o_x   = r_b_x;
    assign o_y   = r_b_y;
    assign o_cr  = r_b_cr;
    assign o_ci  = r_b_ci;

endmodule

FILE: hw/rtl/mandelbrot_escape_iteration_unit.sv
// Escape-time iteration unit: ring of mbe_cell iteration cells with entry,
// in-order exit and output register. Depends on mbe_pkg, mbe_cell, assert_macros.svh.
//
//  channel   | direction | transaction contents (low bit first)
//  ----------+-----------+------------------------------------------
//  s_axis    | in        | c_real, c_imag (COORD_WIDTH each)
//  m_axis    | out       | iteration_count (16)
//  cfg       | in        | iteration limit (16)
//
// The ring holds 2*NUM_CELLS slots, so up to 2*NUM_CELLS points iterate
// at once. A point that escapes after n good updates is marked done after
// n+1 or n+2 cell passes; at the limit n it takes n+1 passes. It then laps
// the ring until it reaches the exit as the oldest point with the output
// register empty; its count then stays in the output register until m_axis
// takes it. A new point enters when an empty or retiring slot passes the entry.
// Reset is synchronous, active low.
module mandelbrot_escape_iteration_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int NUM_CELLS   = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // c_real, c_imag, zero fill to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // iteration_count
    output logic [mbe_pkg::CNT_W-1:0]             m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mbe_pkg::CNT_W-1:0]             i_cfg_data
);
    import mbe_pkg::*;

    `include "assert_macros.svh"

    localparam int ZW    = FRAC_BITS + 3;
    localparam int SLOTS = 2 * NUM_CELLS;
    localparam int TAG_W = $clog2(SLOTS) + 1;
    localparam logic [TAG_W-1:0] SLOTS_T = TAG_W'(SLOTS);

    logic [CNT_W-1:0]              r_max_iter;
    logic [TAG_W-1:0]              r_head_tag, r_tail_tag;
    logic                          r_out_valid;
    logic [CNT_W-1:0]              r_out_data;

    t_slot_ctl                     w_ctl [NUM_CELLS+1];
    logic [TAG_W-1:0]              w_tag [NUM_CELLS+1];
    logic signed [ZW-1:0]          w_x   [NUM_CELLS+1];
    logic signed [ZW-1:0]          w_y   [NUM_CELLS+1];
    logic signed [COORD_WIDTH-1:0] w_cr  [NUM_CELLS+1];
    logic signed [COORD_WIDTH-1:0] w_ci  [NUM_CELLS+1];

    logic w_retire, w_slot_free, w_accept, w_any_live;
    logic [TAG_W-1:0]              w_in_flight;

    // the ring closes from the last cell back to the entry
    assign w_retire    = w_ctl[NUM_CELLS].valid && w_ctl[NUM_CELLS].done &&
                         (w_tag[NUM_CELLS] == r_head_tag) && !r_out_valid;
    assign w_slot_free = !w_ctl[NUM_CELLS].valid || w_retire;
    assign w_accept    = s_axis_tvalid && w_slot_free;

    assign s_axis_tready = w_slot_free;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        w_ctl[0] = w_ctl[NUM_CELLS];
        w_tag[0] = w_tag[NUM_CELLS];
        w_x[0]   = w_x[NUM_CELLS];
        w_y[0]   = w_y[NUM_CELLS];
        w_cr[0]  = w_cr[NUM_CELLS];
        w_ci[0]  = w_ci[NUM_CELLS];
        priority if (w_accept) begin
            w_ctl[0].valid = 1'b1;
            w_ctl[0].done  = 1'b0;
            w_ctl[0].pend  = 1'b0;
            w_ctl[0].count = '0;
            w_tag[0]       = r_tail_tag;
            w_x[0]         = '0;
            w_y[0]         = '0;
            w_cr[0]        = s_axis_tdata[COORD_WIDTH-1:0];
            w_ci[0]        = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end else if (w_retire) begin
            w_ctl[0].valid = 1'b0;
        end else begin
            w_ctl[0].valid = w_ctl[NUM_CELLS].valid;
        end
    end

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        mbe_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .TAG_W       (TAG_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_max_iter (r_max_iter),
            .i_ctl      (w_ctl[k]),
            .i_tag      (w_tag[k]),
            .i_x        (w_x[k]),
            .i_y        (w_y[k]),
            .i_cr       (w_cr[k]),
            .i_ci       (w_ci[k]),
            .o_ctl      (w_ctl[k+1]),
            .o_tag      (w_tag[k+1]),
            .o_x        (w_x[k+1]),
            .o_y        (w_y[k+1]),
            .o_cr       (w_cr[k+1]),
            .o_ci       (w_ci[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= MAX_ITER_RESET;
            r_head_tag  <= '0;
            r_tail_tag  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_iter <= i_cfg_data;
            end
            if (w_accept) begin
                r_tail_tag <= r_tail_tag + 1'b1;
            end
            if (w_retire) begin
                r_head_tag  <= r_head_tag + 1'b1;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_retire) begin
            r_out_data <= w_ctl[NUM_CELLS].count;
        end
    end

    always_comb begin
        w_any_live = 1'b0;
        for (int k = 1; k <= NUM_CELLS; k++) begin
            w_any_live = w_any_live | w_ctl[k].valid;
        end
    end

    assign w_in_flight = r_tail_tag - r_head_tag;

    `MBE_ASSERT(a_inflight_bound, i_clk, i_rst_n, (w_in_flight <= SLOTS_T), "ring overfilled")
    `MBE_ASSERT_IMPL(a_empty_ring, i_clk, i_rst_n, (w_in_flight == '0), !w_any_live, "stray slot")
    `MBE_ASSERT_IMPL(a_retire_owned, i_clk, i_rst_n, w_retire, (w_in_flight != '0), "stray retire")

endmodule
